### src/hdg_pkg.sv
// ----------------------------------------------------------------------------
// hdg_pkg: shared definitions for the heading unit
// Widths, CORDIC angle table, fixed angle constants and the side-band
// struct that travels with each transaction through the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdg_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int FRAC_BITS    = 8;

   localparam int IN_W    = 32;
   localparam int HEAD_W  = 18;
   localparam int GUARD_BITS = 24;
   localparam int ANG_FRAC   = 24;
   localparam int TAB_LEN    = 24;
   localparam int STEPS_USED = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

   // A difference of two coordinates needs one bit more than a coordinate.
   localparam int DIFF_W = COORD_WIDTH + 1;
   // Scaled vector plus headroom for the CORDIC gain and the diagonal length.
   localparam int DATA_W = DIFF_W + GUARD_BITS + 2;
   // Angles up to 270 degrees with ANG_FRAC fraction bits, plus sign.
   localparam int ANG_W  = ANG_FRAC + 10;
   localparam int RND_SH = ANG_FRAC - FRAC_BITS;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [HEAD_W-1:0] head_type;
   typedef logic signed [IN_W-1:0]   coord_type;

   typedef struct packed {
      logic dy_zero;
      logic dy_neg;
      logic dx_pos;
   } side_type;

   // atan(2^-i) in degrees with ANG_FRAC fraction bits, rounded to nearest.
   localparam ang_type ATAN_TAB [TAB_LEN] = '{
      ang_type'(754974720), ang_type'(445687602), ang_type'(235489088),
      ang_type'(119537938), ang_type'(60000934),  ang_type'(30029717),
      ang_type'(15018523),  ang_type'(7509720),   ang_type'(3754917),
      ang_type'(1877466),   ang_type'(938734),    ang_type'(469367),
      ang_type'(234684),    ang_type'(117342),    ang_type'(58671),
      ang_type'(29335),     ang_type'(14668),     ang_type'(7334),
      ang_type'(3667),      ang_type'(1833),      ang_type'(917),
      ang_type'(458),       ang_type'(229),       ang_type'(115)
   };

   localparam ang_type DEG90    = ang_type'(90) << ANG_FRAC;
   localparam ang_type DEG180   = ang_type'(180) << ANG_FRAC;
   localparam ang_type DEG270   = DEG90 + DEG180;
   localparam ang_type RND_HALF = ang_type'(1) << (RND_SH - 1);

   localparam head_type HEAD_POS = head_type'(ang_type'(90) << FRAC_BITS);
   localparam head_type HEAD_NEG = head_type'(-(ang_type'(90) << FRAC_BITS));

endpackage

### src/hdg_if.sv
// ----------------------------------------------------------------------------
// hdg_if: valid/ready channels of the heading unit
// Request channel carrying a point pair and response channel carrying the
// heading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hdg_req_if;
   import hdg_pkg::*;

   logic      valid;
   logic      ready;
   coord_type cur_x;
   coord_type cur_y;
   coord_type next_x;
   coord_type next_y;

   modport source (output valid, output cur_x, output cur_y, output next_x,
                   output next_y, input ready);
   modport sink   (input valid, input cur_x, input cur_y, input next_x,
                   input next_y, output ready);
endinterface

interface hdg_rsp_if;
   import hdg_pkg::*;

   logic     valid;
   logic     ready;
   head_type heading;

   modport source (output valid, output heading, input ready);
   modport sink   (input valid, input heading, output ready);
endinterface

### src/hdg_cordic.sv
// ----------------------------------------------------------------------------
// hdg_cordic: pipelined CORDIC vectoring
// One register stage per iteration drives y towards zero and accumulates
// the rotated angle in degrees. Each stage holds its own valid bit and
// stalls only when the stage after it is full and cannot move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdg_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hdg_pkg::data_type in_x,
   input  hdg_pkg::data_type in_y,
   input  hdg_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output hdg_pkg::ang_type  out_z,
   output hdg_pkg::side_type out_side
);
   import hdg_pkg::*;

   localparam int LAST = STEPS_USED - 1;
   localparam ang_type Z_BOUND = ang_type'(100) << ANG_FRAC;

   logic     vld_ff  [STEPS_USED];
   data_type x_ff    [STEPS_USED];
   data_type y_ff    [STEPS_USED];
   ang_type  z_ff    [STEPS_USED];
   side_type side_ff [STEPS_USED];
   logic [STEPS_USED-1:0] adv;

   for (genvar k = 0; k < STEPS_USED; k++) begin : g_step
      logic     v_src;
      data_type x_src;
      data_type y_src;
      ang_type  z_src;
      side_type s_src;
      logic     nxt_rdy;
      data_type x_in;
      data_type y_in;
      ang_type  z_in;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign x_src = in_x;
         assign y_src = in_y;
         assign z_src = '0;
         assign s_src = in_side;
      end else begin : g_next
         assign v_src = vld_ff[k-1];
         assign x_src = x_ff[k-1];
         assign y_src = y_ff[k-1];
         assign z_src = z_ff[k-1];
         assign s_src = side_ff[k-1];
      end

      if (k == LAST) begin : g_tail
         assign nxt_rdy = out_ready;
      end else begin : g_mid
         assign nxt_rdy = adv[k+1];
      end

      assign adv[k] = !vld_ff[k] || nxt_rdy;

      // Rotate towards the x axis: the sign of y picks the direction.
      always_comb begin
         if (!y_src[DATA_W-1]) begin
            x_in = x_src + (y_src >>> k);
            y_in = y_src - (x_src >>> k);
            z_in = z_src + ATAN_TAB[k];
         end else begin
            x_in = x_src - (y_src >>> k);
            y_in = y_src + (x_src >>> k);
            z_in = z_src - ATAN_TAB[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k] && v_src) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
            side_ff[k] <= s_src;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[LAST];
   assign out_z     = z_ff[LAST];
   assign out_side  = side_ff[LAST];

   // The x component starts non-negative and only ever grows in magnitude.
   a_x_nonneg : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> !x_ff[LAST][DATA_W-1])
      else $error("CORDIC x component went negative");

   a_z_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> (z_ff[LAST] <= Z_BOUND) && (z_ff[LAST] >= -Z_BOUND))
      else $error("CORDIC angle beyond the sum of the step angles");

   a_tail_hold : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !out_ready |=> vld_ff[LAST] && $stable(z_ff[LAST]))
      else $error("CORDIC result changed while stalled");

endmodule

### src/heading_from_two_points.sv
// ----------------------------------------------------------------------------
// heading_from_two_points: heading from a current point to a next point
// The unit takes one point pair per clock cycle when not stalled and returns
// the heading in 1/256 degree, measured from +y towards +x, ranging from -90
// to 270 degrees. Two stages form the differences and the scaled vector, one
// stage per CORDIC iteration (16) follows, then one stage limits and offsets
// the angle and the response register rounds it. Every stage carries its own
// valid bit, so gaps in the flow are filled while a response waits, and a
// stall on the response side holds each full stage in place once the stages
// after it are full. A zero dy gives exactly +90 degrees when dx is positive
// and -90 degrees otherwise. There is no state beyond the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heading_from_two_points (
   input logic        clock,
   input logic        reset,
   hdg_req_if.sink    req_chan,
   hdg_rsp_if.source  rsp_chan
);
   import hdg_pkg::*;

   // Difference stage.
   logic     f0_vld_ff;
   diff_type dx_ff;
   diff_type dy_ff;
   diff_type dx_in;
   diff_type dy_in;
   logic     f0_adv;

   // Vector set-up stage.
   logic     f1_vld_ff;
   data_type x_ff;
   data_type y_ff;
   side_type side_ff;
   data_type x_in;
   data_type y_in;
   side_type side_in;
   logic     f1_adv;

   // CORDIC pipeline.
   logic     cor_in_ready;
   logic     cor_out_valid;
   ang_type  cor_z;
   side_type cor_side;

   // Limit and offset stage.
   logic     b0_vld_ff;
   ang_type  zc_ff;
   side_type b0_side_ff;
   ang_type  zc_in;
   logic     b0_adv;

   // Response register.
   logic     rsp_vld_ff;
   head_type head_ff;
   head_type head_in;
   ang_type  rnd;
   logic     out_adv;

   data_type dx_w;
   data_type dy_w;

   assign f0_adv  = !f0_vld_ff || f1_adv;
   assign f1_adv  = !f1_vld_ff || cor_in_ready;
   assign b0_adv  = !b0_vld_ff || out_adv;
   assign out_adv = !rsp_vld_ff || rsp_chan.ready;

   assign req_chan.ready = f0_adv;

   assign dx_in = diff_type'(signed'(req_chan.next_x[COORD_WIDTH-1:0]))
                - diff_type'(signed'(req_chan.cur_x[COORD_WIDTH-1:0]));
   assign dy_in = diff_type'(signed'(req_chan.next_y[COORD_WIDTH-1:0]))
                - diff_type'(signed'(req_chan.cur_y[COORD_WIDTH-1:0]));

   // For a negative dy the vector is mirrored through the origin, so the
   // CORDIC always works in the right half plane and 180 degrees are added later.
   assign dx_w = data_type'(dx_ff);
   assign dy_w = data_type'(dy_ff);

   always_comb begin
      side_in.dy_zero = (dy_ff == '0);
      side_in.dy_neg  = dy_ff[DIFF_W-1];
      side_in.dx_pos  = !dx_ff[DIFF_W-1] && (dx_ff != '0);
      if (side_in.dy_neg) begin
         x_in = (-dy_w) <<< GUARD_BITS;
         y_in = (-dx_w) <<< GUARD_BITS;
      end else begin
         x_in = dy_w <<< GUARD_BITS;
         y_in = dx_w <<< GUARD_BITS;
      end
   end

   always_comb begin
      if (cor_z > DEG90) begin
         zc_in = DEG90;
      end else if (cor_z < -DEG90) begin
         zc_in = -DEG90;
      end else begin
         zc_in = cor_z;
      end
      if (cor_side.dy_neg) begin
         zc_in = zc_in + DEG180;
      end
   end

   // Round half towards plus infinity, then keep the low bits of the result.
   assign rnd = (zc_ff + RND_HALF) >>> RND_SH;

   always_comb begin
      if (b0_side_ff.dy_zero) begin
         head_in = b0_side_ff.dx_pos ? HEAD_POS : HEAD_NEG;
      end else begin
         head_in = rnd[HEAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_vld_ff  <= 1'b0;
         f1_vld_ff  <= 1'b0;
         b0_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (f0_adv) begin
            f0_vld_ff <= req_chan.valid;
         end
         if (f1_adv) begin
            f1_vld_ff <= f0_vld_ff;
         end
         if (b0_adv) begin
            b0_vld_ff <= cor_out_valid;
         end
         if (out_adv) begin
            rsp_vld_ff <= b0_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f0_adv && req_chan.valid) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (f1_adv && f0_vld_ff) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         side_ff <= side_in;
      end
      if (b0_adv && cor_out_valid) begin
         zc_ff      <= zc_in;
         b0_side_ff <= cor_side;
      end
      if (out_adv && b0_vld_ff) begin
         head_ff <= head_in;
      end
   end

   hdg_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f1_vld_ff),
      .in_ready  (cor_in_ready),
      .in_x      (x_ff),
      .in_y      (y_ff),
      .in_side   (side_ff),
      .out_valid (cor_out_valid),
      .out_ready (b0_adv),
      .out_z     (cor_z),
      .out_side  (cor_side)
   );

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.heading = head_ff;

   a_side_flags : assert property (@(posedge clock) disable iff (reset)
      f1_vld_ff |-> !(side_ff.dy_zero && side_ff.dy_neg))
      else $error("Zero dy flagged as negative");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      b0_vld_ff |-> (zc_ff >= -DEG90) && (zc_ff <= DEG270))
      else $error("Limited angle outside -90 to 270 degrees");

   a_diff_hold : assert property (@(posedge clock) disable iff (reset)
      f0_vld_ff && !f1_adv |=> f0_vld_ff && $stable(dx_ff) && $stable(dy_ff))
      else $error("Difference stage lost or changed a stalled transaction");

endmodule

### bench/heading_from_two_points_tb.sv
// ----------------------------------------------------------------------------
// heading_from_two_points_tb: self-checking bench for the heading unit
// Point pairs go in over the request channel and headings come back over
// the response channel. A scoreboard works out each heading with its own
// CORDIC vectoring model and compares the responses in order. Fixed corner
// cases come first, then random pairs with idle and stall bursts on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heading_from_two_points_tb;
   import hdg_pkg::*;

   localparam int   WATCHDOG_LIMIT = 1000;
   localparam int   DRAIN_CYCLES   = 40;
   localparam int   CHUNK_ITEMS    = 50;
   localparam int   CHUNKS         = 19;
   localparam int   QUIET_CHUNKS   = 3;
   localparam coord_type C_MIN = coord_type'(32'h8000_0000);
   localparam coord_type C_MAX = coord_type'(32'h7FFF_FFFF);

   // atan(2^-i) in degrees with 24 fraction bits.
   localparam longint ARCTAN_DEG [24] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   class heading_scoreboard;
      head_type    expected_q [$];
      int unsigned pairs_seen;
      int unsigned headings_checked;
      int unsigned mismatches;

      function head_type predict_heading(coord_type cx, coord_type cy,
                                         coord_type nx, coord_type ny);
         longint dx, dy, vx, vy, ang, xs, ys, rounded, right_angle;
         int     steps, rnd_shift;
         dx          = longint'(nx) - longint'(cx);
         dy          = longint'(ny) - longint'(cy);
         steps       = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
         rnd_shift   = 24 - FRAC_BITS;
         right_angle = longint'(90) <<< 24;
         if (dy == 0) begin
            // A level step points due east or due west; coincident points
            // fall on the west side.
            rounded = (dx > 0) ? (longint'(90) <<< FRAC_BITS)
                               : -(longint'(90) <<< FRAC_BITS);
         end else begin
            vx  = ((dy > 0) ? dy : -dy) <<< 24;
            vy  = ((dy > 0) ? dx : -dx) <<< 24;
            ang = 0;
            for (int i = 0; i < steps; i++) begin
               xs = vx >>> i;
               ys = vy >>> i;
               if (vy >= 0) begin
                  vx  = vx + ys;
                  vy  = vy - xs;
                  ang = ang + ARCTAN_DEG[i];
               end else begin
                  vx  = vx - ys;
                  vy  = vy + xs;
                  ang = ang - ARCTAN_DEG[i];
               end
            end
            if (ang > right_angle)
               ang = right_angle;
            if (ang < -right_angle)
               ang = -right_angle;
            if (dy < 0)
               ang = ang + (longint'(180) <<< 24);
            rounded = (ang + (longint'(1) <<< (rnd_shift - 1))) >>> rnd_shift;
         end
         return head_type'(rounded);
      endfunction

      function void note_pair(coord_type cx, coord_type cy,
                              coord_type nx, coord_type ny);
         expected_q.push_back(predict_heading(cx, cy, nx, ny));
         pairs_seen++;
      endfunction

      function void check_heading(head_type got);
         head_type want;
         headings_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: heading %0d arrived with no point pair outstanding",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            mismatches++;
            $display("%0t: heading mismatch, expected %0d, actual %0d",
                     $time, want, got);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   source_idle = 1'b0;
   bit   sink_idle   = 1'b0;
   int   quiet_cycles = 0;

   heading_scoreboard scoreboard = new();

   hdg_req_if req_chan ();
   hdg_rsp_if rsp_chan ();

   heading_from_two_points DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Both channels are observed at the rising edge, before any update.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            scoreboard.note_pair(req_chan.cur_x, req_chan.cur_y,
                                 req_chan.next_x, req_chan.next_y);
         if (rsp_chan.valid && rsp_chan.ready)
            scoreboard.check_heading(rsp_chan.heading);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d headings outstanding",
                  $time, WATCHDOG_LIMIT, scoreboard.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: while sink_idle is set, ready drops for bursts of random length.
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 5);
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_pair(input coord_type cx, input coord_type cy,
                            input coord_type nx, input coord_type ny);
      int gap;
      if (source_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cur_x  <= cx;
      req_chan.cur_y  <= cy;
      req_chan.next_x <= nx;
      req_chan.next_y <= ny;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Signed step whose magnitude is spread over many octaves.
   function automatic coord_type rand_delta(input int min_shift);
      return coord_type'($signed($urandom) >>> $urandom_range(min_shift, 31));
   endfunction

   task automatic send_random_pair();
      coord_type cx, cy, nx, ny, d;
      cx = coord_type'($urandom);
      cy = coord_type'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            nx = coord_type'($urandom);
            ny = coord_type'($urandom);
         end
         3, 4: begin
            nx = cx + rand_delta(20);
            ny = cy + rand_delta(20);
         end
         5: begin
            nx = cx + rand_delta(0);
            ny = cy + rand_delta(0);
         end
         6: begin
            nx = cx + rand_delta(0);
            ny = cy;
         end
         7: begin
            nx = cx;
            ny = cy + rand_delta(0);
         end
         8: begin
            // Diagonal steps sit exactly on a table boundary.
            d  = rand_delta(8);
            nx = cx + d;
            ny = ($urandom_range(0, 1) == 0) ? cy + d : cy - d;
         end
         default: begin
            nx = ($urandom_range(0, 3) == 0) ? cx : cx + rand_delta(0);
            ny = ($urandom_range(0, 3) == 0) ? cy : cy + rand_delta(16);
         end
      endcase
      send_pair(cx, cy, nx, ny);
   endtask

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.cur_x  = '0;
      req_chan.cur_y  = '0;
      req_chan.next_x = '0;
      req_chan.next_y = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Level steps, coincident points, the four axes and the diagonals.
      send_pair(0, 0, 0, 0);
      send_pair(0, 0, 5, 0);
      send_pair(0, 0, -5, 0);
      send_pair(0, 0, 0, 7);
      send_pair(0, 0, 0, -7);
      send_pair(0, 0, 3, 3);
      send_pair(0, 0, -3, 3);
      send_pair(0, 0, 3, -3);
      send_pair(0, 0, -3, -3);
      send_pair(-1, -1, 0, 0);
      // Full-range differences in every quadrant.
      send_pair(C_MIN, C_MIN, C_MAX, C_MAX);
      send_pair(C_MAX, C_MAX, C_MIN, C_MIN);
      send_pair(C_MIN, C_MAX, C_MAX, C_MIN);
      send_pair(C_MAX, C_MIN, C_MIN, C_MAX);
      // Tiny dy vs huge dx hits the angle limits; then huge dy vs tiny dx.
      send_pair(C_MIN, 0, C_MAX, 1);
      send_pair(C_MAX, 0, C_MIN, 1);
      send_pair(C_MIN, 1, C_MAX, 0);
      send_pair(C_MAX, 1, C_MIN, 0);
      send_pair(C_MIN, 0, C_MAX, 0);
      send_pair(C_MAX, 5, C_MIN, 5);
      send_pair(0, C_MIN, 0, C_MAX);
      send_pair(0, C_MAX, 0, C_MIN);
      send_pair(0, 0, 1, C_MAX);
      send_pair(0, 0, -1, C_MIN);

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         if (chunk >= CHUNKS - QUIET_CHUNKS) begin
            source_idle = 1'b0;
            sink_idle   = 1'b0;
         end else begin
            source_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
         end
         repeat (CHUNK_ITEMS) send_random_pair();
      end
      req_chan.valid <= 1'b0;

      while (scoreboard.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d point pairs, corner cases and random, with idle bursts;",
               scoreboard.pairs_seen);
      $display("checked %0d headings and found %0d mismatches.",
               scoreboard.headings_checked, scoreboard.mismatches);
      if (scoreboard.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
